>>> design/wsm_pkg.sv
// Shared types and constants of the wind speed meter.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package wsm_pkg;

  // Field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEBOUNCE_W = 20;
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned MS_W       = 24;
  localparam int unsigned KMH_W      = 26;
  localparam int unsigned OUT_DATA_W = 64;

  // Serial multiplier: operand A is taken whole, operand B one bit a cycle
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // sum * gain is Q16.24 in 40 bits
  localparam int unsigned RAW_W   = SUM_W + COEF_W;
  localparam int unsigned FRAC_DROP = 8;
  localparam int unsigned V_W     = RAW_W - FRAC_DROP;

  // km/h = v * 14746 / 4096
  localparam logic [MUL_B_W-1:0] KMH_FACTOR = MUL_B_W'(14746);
  localparam int unsigned KMH_SHIFT = 12;

  // Reset values of the registers
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(6000);
  localparam logic [COEF_W-1:0]     GAIN_RST     = COEF_W'(143073);
  localparam logic [COEF_W-1:0]     OFFSET_RST   = COEF_W'(2528904);

  localparam int unsigned WINDOW_DEPTH_DEF = 140;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET   = 2'd2;

  // Item kinds
  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_PERIOD = 1'b1;

  // Control toward the edge counter
  typedef struct packed {
    logic start;
    logic clear;
  } edge_ctrl_t;

  // Request toward the serial multiplier
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  // Control toward the window ring
  typedef struct packed {
    logic               rd;
    logic               upd;
    logic [COUNT_W-1:0] count;
  } ring_ctrl_t;

endpackage

>>> design/wsm_edge_counter.sv
// Debounced edge counter: bit-serial wrapping subtract and compare of an
// edge time against the last accepted edge. Depends on wsm_pkg.
`timescale 1ns / 1ps

module wsm_edge_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsm_pkg::edge_ctrl_t           ctrl_i,
  input  logic [wsm_pkg::TIME_W-1:0]    time_i,
  input  logic [wsm_pkg::DEBOUNCE_W-1:0] debounce_i,
  output logic                          busy_o,
  output logic [wsm_pkg::COUNT_W-1:0]   count_o
);
  import wsm_pkg::*;

  localparam int unsigned CNT_W = $clog2(TIME_W);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [TIME_W-1:0]     t_q, t_d;
  logic [TIME_W-1:0]     last_q, last_rot;
  logic [DEBOUNCE_W-1:0] db_q;
  logic                  borrow_q, borrow_d;
  logic                  gt_q, gt_d;
  logic [COUNT_W-1:0]    count_q;
  logic                  diff_bit;
  logic                  last_bit;

  // One bit of t - last per cycle, LSB first; track diff > debounce
  always_comb begin
    diff_bit = t_q[0] ^ last_q[0] ^ borrow_q;
    borrow_d = (~t_q[0] & last_q[0]) | (~(t_q[0] ^ last_q[0]) & borrow_q);
    gt_d     = (diff_bit != db_q[0]) ? diff_bit : gt_q;
    t_d      = {t_q[0], t_q[TIME_W-1:1]};
    last_rot = {last_q[0], last_q[TIME_W-1:1]};
    last_bit = (cnt_q == CNT_W'(TIME_W - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      last_q   <= '0;
      count_q  <= '0;
      borrow_q <= 1'b0;
      gt_q     <= 1'b0;
    end else if (ctrl_i.start) begin
      busy_q   <= 1'b1;
      cnt_q    <= '0;
      borrow_q <= 1'b0;
      gt_q     <= 1'b0;
    end else if (busy_q) begin
      cnt_q    <= cnt_q + 1'b1;
      borrow_q <= borrow_d;
      gt_q     <= gt_d;
      // t has rotated back to its loaded value on the last bit
      if (last_bit) begin
        busy_q <= 1'b0;
        if (gt_d) begin
          last_q <= t_d;
          if (count_q != '1) begin
            count_q <= count_q + 1'b1;
          end
        end else begin
          last_q <= last_rot;
        end
      end else begin
        last_q <= last_rot;
      end
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end
  end

  // Operand shift registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      t_q  <= time_i;
      db_q <= debounce_i;
    end else if (busy_q) begin
      t_q  <= t_d;
      db_q <= {1'b0, db_q[DEBOUNCE_W-1:1]};
    end
  end

  assign busy_o  = busy_q;
  assign count_o = count_q;

endmodule

>>> design/wsm_serial_mul.sv
// Shift-add multiplier, one bit of operand B per cycle.
// Depends on wsm_pkg.
`timescale 1ns / 1ps

module wsm_serial_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wsm_pkg::mul_req_t           req_i,
  output logic                        busy_o,
  output logic [wsm_pkg::PROD_W-1:0]  prod_o
);
  import wsm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_B_W);

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [PROD_W-1:0]  acc_q, acc_d;
  logic [MUL_A_W:0]   part_sum;

  // Add A into the upper half when the current B bit is set, shift right
  always_comb begin
    part_sum = {1'b0, acc_q[PROD_W-1:MUL_B_W]} + (b_q[0] ? {1'b0, a_q} : '0);
    acc_d    = {part_sum, acc_q[MUL_B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(MUL_B_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= {1'b0, b_q[MUL_B_W-1:1]};
      acc_q <= acc_d;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

>>> design/wsm_ring.sv
// Window ring of period counts with its running sum. Slot memory with
// registered read; per-slot valid bits make unwritten slots read as zero.
// Depends on wsm_pkg.
`timescale 1ns / 1ps

module wsm_ring #(
  parameter int unsigned WINDOW_DEPTH = wsm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wsm_pkg::ring_ctrl_t        ctrl_i,
  output logic [wsm_pkg::SUM_W-1:0]  sum_o
);
  import wsm_pkg::*;

  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic [COUNT_W-1:0] mem_q [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] vld_q;
  logic [IDX_W-1:0]   slot_q;
  logic [COUNT_W-1:0] rd_data_q;
  logic               rd_vld_q;
  logic [SUM_W-1:0]   sum_q;
  logic [COUNT_W-1:0] old_count;

  assign old_count = rd_vld_q ? rd_data_q : '0;

  // Slot memory: read the oldest count, then overwrite it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_data_q <= mem_q[slot_q];
    end
    if (ctrl_i.upd) begin
      mem_q[slot_q] <= ctrl_i.count;
    end
  end

  // Valid bits, slot pointer and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      slot_q   <= '0;
      sum_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.rd) begin
        rd_vld_q <= vld_q[slot_q];
      end
      if (ctrl_i.upd) begin
        vld_q[slot_q] <= 1'b1;
        sum_q <= sum_q - SUM_W'(old_count) + SUM_W'(ctrl_i.count);
        if (slot_q == IDX_W'(WINDOW_DEPTH - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
    end
  end

  assign sum_o = sum_q;

endmodule

>>> design/debounced_pulse_wind_speed_meter.sv
// Wind speed meter top level: sequencer, registers and output stage.
// Depends on wsm_pkg, wsm_edge_counter, wsm_serial_mul and wsm_ring.
//
// Usage: items enter on the s_axis channel. tuser[0] selects the kind:
// 0 is a rising anemometer edge with its microsecond time in tdata, 1 closes
// a sample period. An edge item yields nothing; it is checked against the
// debounce time by a bit-serial subtractor, one bit per cycle, and s_axis is
// ready again once it is done. A period item stores the count in the window
// ring, updates the sum and runs two shift-add multiplies (sum * gain, then
// m/s * 14746); it yields one result on m_axis, and s_axis is ready again in
// the same cycle that the result appears.
// Results sit in an output register: the block takes further edge items
// while a result waits, and a period item only finishes once that register
// is free, so a stalled receiver holds back at most one completed result.
// Write registers on the cfg channel (always ready) only while idle; the block
// does not enforce it. Reset restores register defaults, zeroes the pulse
// count, last edge time and running sum, and marks every ring slot empty at once.
`timescale 1ns / 1ps

module debounced_pulse_wind_speed_meter #(
  parameter int unsigned WINDOW_DEPTH = wsm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // cfg_data_i: register value, low bits used
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wsm_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [wsm_pkg::COEF_W-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: [31:0] time_us
  input  logic [wsm_pkg::TIME_W-1:0]        s_axis_tdata_i,
  // tuser: [0] command
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: [23:0] speed_ms, [49:24] speed_kmh, [57:50] period_count,
  //        [58] clamped, [63:59] zero
  output logic [wsm_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import wsm_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_EDGE   = 9'b000000010,
    ST_READ   = 9'b000000100,
    ST_UPDATE = 9'b000001000,
    ST_MUL_GO = 9'b000010000,
    ST_MUL1   = 9'b000100000,
    ST_OFFSET = 9'b001000000,
    ST_MUL2   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [COEF_W-1:0]     gain_q;
  logic [COEF_W-1:0]     offset_q;

  logic                  in_accept;
  edge_ctrl_t            edge_ctrl;
  logic                  edge_busy;
  logic [COUNT_W-1:0]    edge_count;
  mul_req_t              mul_req;
  logic                  mul_busy;
  logic [PROD_W-1:0]     prod;
  ring_ctrl_t            ring_ctrl;
  logic [SUM_W-1:0]      win_sum;

  logic [COUNT_W-1:0]    count_q;
  logic [V_W-1:0]        v_q, v_d;
  logic                  clamp_q, clamp_d;
  logic [RAW_W:0]        diff;
  logic [MS_W-1:0]       ms_sat;
  logic [KMH_W-1:0]      kmh_sat;
  logic                  out_free;

  logic                  out_valid_q;
  logic [MS_W-1:0]       out_ms_q;
  logic [KMH_W-1:0]      out_kmh_q;
  logic [COUNT_W-1:0]    out_count_q;
  logic                  out_clamp_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      gain_q     <= GAIN_RST;
      offset_q   <= OFFSET_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_DEBOUNCE: debounce_q <= cfg_data_i[DEBOUNCE_W-1:0];
        REG_GAIN:     gain_q     <= cfg_data_i;
        REG_OFFSET:   offset_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Sub-unit control
  always_comb begin
    edge_ctrl.start = in_accept && (s_axis_tuser_i == CMD_EDGE);
    edge_ctrl.clear = in_accept && (s_axis_tuser_i == CMD_PERIOD);

    ring_ctrl.rd    = (state_q == ST_READ);
    ring_ctrl.upd   = (state_q == ST_UPDATE);
    ring_ctrl.count = count_q;

    // Offset step: clamp test and Q16.16 speed
    diff    = {1'b0, prod[RAW_W-1:0]} - (RAW_W + 1)'(offset_q);
    clamp_d = diff[RAW_W];
    v_d     = clamp_d ? '0 : diff[RAW_W-1:FRAC_DROP];

    mul_req.start = (state_q == ST_MUL_GO) || (state_q == ST_OFFSET);
    if (state_q == ST_MUL_GO) begin
      mul_req.a = MUL_A_W'(gain_q);
      mul_req.b = MUL_B_W'(win_sum);
    end else begin
      mul_req.a = MUL_A_W'(v_d);
      mul_req.b = KMH_FACTOR;
    end

    // Saturate both speeds
    ms_sat  = (|v_q[V_W-1:MS_W]) ? '1 : v_q[MS_W-1:0];
    kmh_sat = (|prod[PROD_W-1:KMH_SHIFT+KMH_W]) ? '1 : prod[KMH_SHIFT+KMH_W-1:KMH_SHIFT];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (s_axis_tuser_i == CMD_EDGE) ? ST_EDGE : ST_READ;
        end
      end
      ST_EDGE:   if (!edge_busy) state_d = ST_IDLE;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_MUL_GO;
      ST_MUL_GO: state_d = ST_MUL1;
      ST_MUL1:   if (!mul_busy) state_d = ST_OFFSET;
      ST_OFFSET: state_d = ST_MUL2;
      ST_MUL2:   if (!mul_busy) state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the closed period's count and the speed between steps
  always_ff @(posedge clk_i) begin
    if (edge_ctrl.clear) begin
      count_q <= edge_count;
    end
    if (state_q == ST_OFFSET) begin
      v_q     <= v_d;
      clamp_q <= clamp_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      out_ms_q    <= ms_sat;
      out_kmh_q   <= kmh_sat;
      out_count_q <= count_q;
      out_clamp_q <= clamp_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_clamp_q, out_count_q, out_kmh_q, out_ms_q};

  wsm_edge_counter u_edge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (edge_ctrl),
    .time_i     (s_axis_tdata_i),
    .debounce_i (debounce_q),
    .busy_o     (edge_busy),
    .count_o    (edge_count)
  );

  wsm_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .busy_o (mul_busy),
    .prod_o (prod)
  );

  wsm_ring #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .sum_o  (win_sum)
  );

  // A clamped result carries zero speeds
  a_clamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[58]) |->
      (m_axis_tdata_o[23:0] == '0) && (m_axis_tdata_o[49:24] == '0))
    else $error("clamped result with nonzero speed");

  // The edge checker and the multiplier never run together
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(edge_busy && mul_busy))
    else $error("edge checker and multiplier busy together");

  // Closing a period restarts the pulse count
  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (s_axis_tuser_i == CMD_PERIOD)) |=> (edge_count == '0))
    else $error("pulse count not cleared at period end");

endmodule

>>> test/debounced_pulse_wind_speed_meter_test.sv
// Self-checking testbench for the debounced pulse wind speed meter.
// Needs wsm_pkg and the block; predicts every reading and checks it field by
// field.
`timescale 1ns / 1ps

module debounced_pulse_wind_speed_meter_test;
  import wsm_pkg::*;

  localparam int unsigned RING_DEPTH    = WINDOW_DEPTH_DEF;
  localparam int unsigned SETTLE_LIMIT  = 50000;
  localparam int unsigned QUIET_CYCLES  = 80;
  localparam int unsigned HOLDOFF_LEN   = 600;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic              cmd;
    logic [TIME_W-1:0] time_us;
  } meter_req_t;

  // Packed so that ms lands in the low bits, as on m_axis_tdata_o
  typedef struct packed {
    logic               clamped;
    logic [COUNT_W-1:0] count;
    logic [KMH_W-1:0]   kmh;
    logic [MS_W-1:0]    ms;
  } wind_reading_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i      = '0;
  logic [COEF_W-1:0]     cfg_data_i      = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [TIME_W-1:0]     s_axis_tdata_i  = '0;
  logic                  s_axis_tuser_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Predicted register contents
  logic [DEBOUNCE_W-1:0] debounce_us = DEBOUNCE_RST;
  logic [COEF_W-1:0]     gain        = GAIN_RST;
  logic [COEF_W-1:0]     offset      = OFFSET_RST;

  // Predicted meter state
  logic [COUNT_W-1:0] hit_count   = '0;
  logic [TIME_W-1:0]  last_hit_us = '0;
  logic [COUNT_W-1:0] window_ring [RING_DEPTH] = '{default: '0};
  int unsigned        ring_slot   = 0;
  logic [SUM_W-1:0]   window_sum  = '0;

  meter_req_t    pending_reqs[$];
  wind_reading_t expected_readings[$];
  int unsigned   mismatch_count = 0;

  // Traffic shaping
  logic              tx_idle_on = 1'b1;
  logic              rx_idle_on = 1'b1;
  logic              rx_blocked = 1'b0;
  bit                holdoff_go = 1'b0;
  int unsigned       tx_gap = 0;
  int unsigned       rx_gap = 0;
  logic [TIME_W-1:0] tick_us = '0;

  debounced_pulse_wind_speed_meter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance the meter by one request; return 1 when it closes a period
  function automatic bit advance_meter(input logic cmd, input logic [TIME_W-1:0] t_us,
                                       output wind_reading_t r);
    logic [TIME_W-1:0]  since_us;
    logic [COUNT_W-1:0] closed;
    logic [RAW_W-1:0]   prod;
    logic [V_W-1:0]     v;
    logic [63:0]        kmh_wide;
    r = '0;
    since_us = t_us - last_hit_us;
    if (cmd == CMD_EDGE) begin
      // Debounce on the wrapping distance to the last counted edge
      if (since_us > TIME_W'(debounce_us)) begin
        if (hit_count != '1) hit_count = hit_count + 1'b1;
        last_hit_us = t_us;
      end
      return 1'b0;
    end
    closed = hit_count;
    hit_count = '0;
    window_sum = window_sum - SUM_W'(window_ring[ring_slot]) + SUM_W'(closed);
    window_ring[ring_slot] = closed;
    ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
    // Scale the window sum, drop the offset, clamp below zero
    prod = RAW_W'(window_sum) * RAW_W'(gain);
    if (prod < RAW_W'(offset)) begin
      r.clamped = 1'b1;
      v = '0;
    end else begin
      v = V_W'((prod - RAW_W'(offset)) >> FRAC_DROP);
    end
    r.ms = (v > V_W'({MS_W{1'b1}})) ? '1 : v[MS_W-1:0];
    kmh_wide = (64'(v) * 64'(KMH_FACTOR)) >> KMH_SHIFT;
    r.kmh = (kmh_wide > 64'({KMH_W{1'b1}})) ? '1 : kmh_wide[KMH_W-1:0];
    r.count = closed;
    return 1'b1;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch in %s: expected %0h, got %0h", what, want, got);
  endfunction

  function automatic void offer(input logic cmd, input logic [TIME_W-1:0] t_us);
    meter_req_t req;
    req.cmd = cmd;
    req.time_us = t_us;
    pending_reqs.push_back(req);
  endfunction

  // Queue a period of edges with random spacing around the debounce time
  function automatic int unsigned queue_gust(input int unsigned n_hits);
    int unsigned r;
    repeat (n_hits) begin
      r = $urandom_range(0, 99);
      if (r < 70) tick_us += TIME_W'(debounce_us) + $urandom_range(1, 3000);
      else if (r < 85) tick_us += $urandom_range(0, debounce_us);
      else if (r < 95) tick_us += TIME_W'(debounce_us);
      else tick_us += $urandom();
      offer(CMD_EDGE, tick_us);
    end
    offer(CMD_PERIOD, $urandom());
    return n_hits + 1;
  endfunction

  // Send requests from the pending queue; predict each accepted one
  always @(posedge clk_i) begin : driver
    wind_reading_t reading;
    meter_req_t    req;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      if (advance_meter(s_axis_tuser_i, s_axis_tdata_i, reading))
        expected_readings.push_back(reading);
      tx_gap = tx_idle_on ? pick_gap() : 0;
    end
    if (s_axis_tvalid_i && !s_axis_tready_o) begin
      // hold the current request until it is taken
    end else if (tx_gap > 0) begin
      tx_gap--;
      s_axis_tvalid_i <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      req = pending_reqs.pop_front();
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= req.time_us;
      s_axis_tuser_i  <= req.cmd;
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // Check readings against the oldest prediction; drive tready with gaps
  always @(posedge clk_i) begin : monitor
    wind_reading_t want;
    wind_reading_t seen;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      seen = m_axis_tdata_o[$bits(wind_reading_t)-1:0];
      if (expected_readings.size() == 0) begin
        note_mismatch("reading with none expected", '0, m_axis_tdata_o);
      end else begin
        want = expected_readings.pop_front();
        if (seen.ms != want.ms) note_mismatch("speed_ms", 64'(want.ms), 64'(seen.ms));
        if (seen.kmh != want.kmh) note_mismatch("speed_kmh", 64'(want.kmh), 64'(seen.kmh));
        if (seen.count != want.count)
          note_mismatch("period_count", 64'(want.count), 64'(seen.count));
        if (seen.clamped != want.clamped)
          note_mismatch("clamped", 64'(want.clamped), 64'(seen.clamped));
        if (m_axis_tdata_o[OUT_DATA_W-1:$bits(wind_reading_t)] != '0)
          note_mismatch("padding", '0,
                        64'(m_axis_tdata_o[OUT_DATA_W-1:$bits(wind_reading_t)]));
      end
    end
    if (!rst_ni || rx_blocked) begin
      m_axis_tready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      rx_gap = rx_idle_on ? pick_gap() : 0;
    end
  end

  // Long receiver hold-off, counted here once the stimulus asks for it
  initial begin : rx_holdoff
    wait (holdoff_go);
    @(posedge clk_i);
    rx_blocked <= 1'b1;
    repeat (HOLDOFF_LEN) @(posedge clk_i);
    rx_blocked <= 1'b0;
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk_i);
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_DEBOUNCE: debounce_us = val[DEBOUNCE_W-1:0];
      REG_GAIN:     gain = val;
      REG_OFFSET:   offset = val;
      default:      ;
    endcase
  endtask

  // Wait until every request is taken and every reading has come back
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while ((pending_reqs.size() != 0 || s_axis_tvalid_i || expected_readings.size() != 0)
           && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [COEF_W-1:0] deb, input logic [COEF_W-1:0] g,
                           input logic [COEF_W-1:0] off, input logic tx_idle,
                           input logic rx_idle, input int unsigned n_items);
    int unsigned queued;
    queued = 0;
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_GAIN, g);
    write_reg(REG_OFFSET, off);
    tx_idle_on <= tx_idle;
    rx_idle_on <= rx_idle;
    tick_us = $urandom();
    while (queued < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: requests of any kind at any time
        repeat ($urandom_range(1, 3)) begin
          offer(1'($urandom_range(0, 1)), $urandom());
          queued++;
        end
      end else if ($urandom_range(0, 99) < 85) begin
        queued += queue_gust($urandom_range(0, 12));
      end else begin
        queued += queue_gust($urandom_range(13, 45));
      end
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty period, first edge against time zero, debounce
    // boundary, timestamp wrap, backwards time, all-ones and all-zeros
    offer(CMD_PERIOD, '0);
    offer(CMD_EDGE, 32'd0);
    offer(CMD_EDGE, 32'd6000);
    offer(CMD_EDGE, 32'd6001);
    offer(CMD_EDGE, 32'd12002);
    offer(CMD_EDGE, 32'd12003);
    offer(CMD_PERIOD, '1);
    offer(CMD_EDGE, 32'hFFFF_FFFF);
    offer(CMD_EDGE, 32'h0000_1000);
    offer(CMD_EDGE, 32'h0000_2000);
    offer(CMD_EDGE, 32'h0000_1000);
    offer(CMD_PERIOD, 32'h5555_5555);
    offer(CMD_EDGE, 32'h5555_5555);
    offer(CMD_EDGE, 32'hAAAA_AAAA);
    offer(CMD_PERIOD, 32'hAAAA_AAAA);
    offer(CMD_PERIOD, '0);
    settle();

    run_phase(COEF_W'(DEBOUNCE_RST), GAIN_RST, OFFSET_RST, 1'b1, 1'b1, 230);

    // Stall the receiver while requests keep coming, periods among them
    tx_idle_on <= 1'b0;
    holdoff_go = 1'b1;
    repeat (8) void'(queue_gust($urandom_range(0, 6)));
    settle();

    // Debounce off, full gain: saturate speeds, then saturate one count
    run_phase('0, '1, '0, 1'b0, 1'b0, 250);
    repeat (270) begin
      tick_us += $urandom_range(1, 4);
      offer(CMD_EDGE, tick_us);
    end
    offer(CMD_PERIOD, $urandom());
    settle();

    // Longest debounce, zero gain, largest offset: every reading clamps
    run_phase('1, '0, '1, 1'b1, 1'b0, 250);

    write_reg(REG_UNUSED, COEF_W'($urandom()));
    run_phase(COEF_W'($urandom_range(0, 20000)), COEF_W'($urandom()), COEF_W'($urandom()),
              1'b0, 1'b1, 230);
    run_phase(24'd1000, 24'h10_0000, 24'h80_0000, 1'b1, 1'b1, 230);
    run_phase(COEF_W'(DEBOUNCE_RST), GAIN_RST, OFFSET_RST, 1'b1, 1'b1, 230);

    settle();
    if (mismatch_count == 0 && expected_readings.size() == 0
        && pending_reqs.size() == 0 && !s_axis_tvalid_i) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
